@@ hw/rtl/tchi_pkg.sv @@
package tchi_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int IO_W           = 32;

  localparam int RF_DEPTH  = 32;
  localparam int ADDR_W    = 5;
  localparam int PC_W      = 7;
  localparam int LD_FIELDS = 5;
  localparam int VERT_N    = 3;

  localparam logic [PC_W-1:0] PC_LAST = 7'd90;

  localparam logic       KIND_LOAD  = 1'b0;
  localparam logic       KIND_QUERY = 1'b1;
  localparam logic [1:0] BAD_IDX    = 2'd3;

  // register file slots; vertex entries sit at field*3 + vertex
  localparam logic [ADDR_W-1:0] R_VX0 = 5'd0;
  localparam logic [ADDR_W-1:0] R_VX1 = 5'd1;
  localparam logic [ADDR_W-1:0] R_VX2 = 5'd2;
  localparam logic [ADDR_W-1:0] R_VY0 = 5'd3;
  localparam logic [ADDR_W-1:0] R_VY1 = 5'd4;
  localparam logic [ADDR_W-1:0] R_VY2 = 5'd5;
  localparam logic [ADDR_W-1:0] R_VL0 = 5'd6;
  localparam logic [ADDR_W-1:0] R_VL1 = 5'd7;
  localparam logic [ADDR_W-1:0] R_VL2 = 5'd8;
  localparam logic [ADDR_W-1:0] R_SX0 = 5'd9;
  localparam logic [ADDR_W-1:0] R_SX1 = 5'd10;
  localparam logic [ADDR_W-1:0] R_SX2 = 5'd11;
  localparam logic [ADDR_W-1:0] R_SY0 = 5'd12;
  localparam logic [ADDR_W-1:0] R_SY1 = 5'd13;
  localparam logic [ADDR_W-1:0] R_SY2 = 5'd14;
  localparam logic [ADDR_W-1:0] R_PX  = 5'd15;
  localparam logic [ADDR_W-1:0] R_PY  = 5'd16;
  localparam logic [ADDR_W-1:0] R_DX1 = 5'd17;
  localparam logic [ADDR_W-1:0] R_DY1 = 5'd18;
  localparam logic [ADDR_W-1:0] R_DX2 = 5'd19;
  localparam logic [ADDR_W-1:0] R_DY2 = 5'd20;
  localparam logic [ADDR_W-1:0] R_T0  = 5'd21;
  localparam logic [ADDR_W-1:0] R_T1  = 5'd22;
  localparam logic [ADDR_W-1:0] R_T2  = 5'd23;
  localparam logic [ADDR_W-1:0] R_T3  = 5'd24;
  localparam logic [ADDR_W-1:0] R_U   = 5'd25;
  localparam logic [ADDR_W-1:0] R_V   = 5'd26;
  localparam logic [ADDR_W-1:0] R_GX0 = 5'd27;
  localparam logic [ADDR_W-1:0] R_GY0 = 5'd28;
  localparam logic [ADDR_W-1:0] R_GX1 = 5'd29;
  localparam logic [ADDR_W-1:0] R_GY1 = 5'd30;
  localparam logic [ADDR_W-1:0] R_ACC = 5'd31;
  // slots reused once their first occupant is dead
  localparam logic [ADDR_W-1:0] R_DET = R_T2;
  localparam logic [ADDR_W-1:0] R_GX2 = R_ACC;
  localparam logic [ADDR_W-1:0] R_GY2 = R_PX;
  localparam logic [ADDR_W-1:0] R_C3  = R_PY;
  localparam logic [ADDR_W-1:0] R_C2  = R_T3;
  localparam logic [ADDR_W-1:0] R_C5  = R_DX1;
  localparam logic [ADDR_W-1:0] R_C4  = R_DY1;
  localparam logic [ADDR_W-1:0] R_C1  = R_DX2;
  localparam logic [ADDR_W-1:0] R_C0  = R_DY2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_LDX = 3'd4,
    OP_LDY = 3'd5,
    OP_CHK = 3'd6,
    OP_FIN = 3'd7
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
    logic [ADDR_W-1:0] rd;
    logic              zero_a;
  } instr_t;

  typedef struct packed {
    logic              latch;
    logic              clr;
    logic              ld_we;
    logic [2:0]        ld_sel;
    op_t               op;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
    logic [ADDR_W-1:0] rd;
    logic              zero_a;
    logic              ex;
    logic              dv;
    logic              wr;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic div_done;
  } sts_t;

  function automatic instr_t mk(op_t op, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                                logic [ADDR_W-1:0] d, logic z);
    instr_t i;
    i.op     = op;
    i.ra     = a;
    i.rb     = b;
    i.rd     = d;
    i.zero_a = z;
    return i;
  endfunction

  // query program
  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      7'd0:  i = mk(OP_LDX, R_PX,  R_PX,  R_PX,  1'b0);
      7'd1:  i = mk(OP_LDY, R_PY,  R_PY,  R_PY,  1'b0);
      7'd2:  i = mk(OP_SUB, R_VX1, R_VX0, R_DX1, 1'b0);
      7'd3:  i = mk(OP_SUB, R_VY1, R_VY0, R_DY1, 1'b0);
      7'd4:  i = mk(OP_SUB, R_VX2, R_VX0, R_DX2, 1'b0);
      7'd5:  i = mk(OP_SUB, R_VY2, R_VY0, R_DY2, 1'b0);
      7'd6:  i = mk(OP_SUB, R_PX,  R_VX0, R_PX,  1'b0);
      7'd7:  i = mk(OP_SUB, R_PY,  R_VY0, R_PY,  1'b0);
      7'd8:  i = mk(OP_MUL, R_DX1, R_DY2, R_T0,  1'b0);
      7'd9:  i = mk(OP_MUL, R_DX2, R_DY1, R_T1,  1'b0);
      7'd10: i = mk(OP_SUB, R_T0,  R_T1,  R_DET, 1'b0);
      7'd11: i = mk(OP_CHK, R_DET, R_DET, R_DET, 1'b0);
      7'd12: i = mk(OP_MUL, R_PX,  R_DY2, R_T0,  1'b0);
      7'd13: i = mk(OP_MUL, R_PY,  R_DX2, R_T1,  1'b0);
      7'd14: i = mk(OP_SUB, R_T0,  R_T1,  R_T3,  1'b0);
      7'd15: i = mk(OP_DIV, R_T3,  R_DET, R_U,   1'b0);
      7'd16: i = mk(OP_MUL, R_PY,  R_DX1, R_T0,  1'b0);
      7'd17: i = mk(OP_MUL, R_PX,  R_DY1, R_T1,  1'b0);
      7'd18: i = mk(OP_SUB, R_T0,  R_T1,  R_T3,  1'b0);
      7'd19: i = mk(OP_DIV, R_T3,  R_DET, R_V,   1'b0);
      7'd20: i = mk(OP_MUL, R_SX0, R_DX1, R_T0,  1'b0);
      7'd21: i = mk(OP_MUL, R_SY0, R_DY1, R_T1,  1'b0);
      7'd22: i = mk(OP_ADD, R_T0,  R_T1,  R_GX0, 1'b0);
      7'd23: i = mk(OP_MUL, R_SX0, R_DX2, R_T0,  1'b0);
      7'd24: i = mk(OP_MUL, R_SY0, R_DY2, R_T1,  1'b0);
      7'd25: i = mk(OP_ADD, R_T0,  R_T1,  R_GY0, 1'b0);
      7'd26: i = mk(OP_MUL, R_SX1, R_DX1, R_T0,  1'b0);
      7'd27: i = mk(OP_MUL, R_SY1, R_DY1, R_T1,  1'b0);
      7'd28: i = mk(OP_ADD, R_T0,  R_T1,  R_GX1, 1'b0);
      7'd29: i = mk(OP_MUL, R_SX1, R_DX2, R_T0,  1'b0);
      7'd30: i = mk(OP_MUL, R_SY1, R_DY2, R_T1,  1'b0);
      7'd31: i = mk(OP_ADD, R_T0,  R_T1,  R_GY1, 1'b0);
      7'd32: i = mk(OP_MUL, R_SX2, R_DX1, R_T0,  1'b0);
      7'd33: i = mk(OP_MUL, R_SY2, R_DY1, R_T1,  1'b0);
      7'd34: i = mk(OP_ADD, R_T0,  R_T1,  R_GX2, 1'b0);
      7'd35: i = mk(OP_MUL, R_SX2, R_DX2, R_T0,  1'b0);
      7'd36: i = mk(OP_MUL, R_SY2, R_DY2, R_T1,  1'b0);
      7'd37: i = mk(OP_ADD, R_T0,  R_T1,  R_GY2, 1'b0);
      7'd38: i = mk(OP_SUB, R_GX2, R_GX0, R_C3,  1'b0);
      7'd39: i = mk(OP_SUB, R_GY1, R_GY0, R_C2,  1'b0);
      // c5 = 3*f2 - 2*gy0 - 3*f0 - gy2
      7'd40: i = mk(OP_ADD, R_VL2, R_VL2, R_T0,  1'b0);
      7'd41: i = mk(OP_ADD, R_T0,  R_VL2, R_T0,  1'b0);
      7'd42: i = mk(OP_ADD, R_GY0, R_GY0, R_T1,  1'b0);
      7'd43: i = mk(OP_SUB, R_T0,  R_T1,  R_T0,  1'b0);
      7'd44: i = mk(OP_ADD, R_VL0, R_VL0, R_T1,  1'b0);
      7'd45: i = mk(OP_ADD, R_T1,  R_VL0, R_T1,  1'b0);
      7'd46: i = mk(OP_SUB, R_T0,  R_T1,  R_T0,  1'b0);
      7'd47: i = mk(OP_SUB, R_T0,  R_GY2, R_C5,  1'b0);
      // c4 = 3*f1 - 2*gx0 - 3*f0 - gx1
      7'd48: i = mk(OP_ADD, R_VL1, R_VL1, R_T0,  1'b0);
      7'd49: i = mk(OP_ADD, R_T0,  R_VL1, R_T0,  1'b0);
      7'd50: i = mk(OP_ADD, R_GX0, R_GX0, R_T1,  1'b0);
      7'd51: i = mk(OP_SUB, R_T0,  R_T1,  R_T0,  1'b0);
      7'd52: i = mk(OP_ADD, R_VL0, R_VL0, R_T1,  1'b0);
      7'd53: i = mk(OP_ADD, R_T1,  R_VL0, R_T1,  1'b0);
      7'd54: i = mk(OP_SUB, R_T0,  R_T1,  R_T0,  1'b0);
      7'd55: i = mk(OP_SUB, R_T0,  R_GX1, R_C4,  1'b0);
      // c1 = -2*f2 + gy0 + 2*f0 + gy2
      7'd56: i = mk(OP_ADD, R_VL2, R_VL2, R_T0,  1'b0);
      7'd57: i = mk(OP_SUB, R_T0,  R_T0,  R_T0,  1'b1);
      7'd58: i = mk(OP_ADD, R_T0,  R_GY0, R_T0,  1'b0);
      7'd59: i = mk(OP_ADD, R_VL0, R_VL0, R_T1,  1'b0);
      7'd60: i = mk(OP_ADD, R_T0,  R_T1,  R_T0,  1'b0);
      7'd61: i = mk(OP_ADD, R_T0,  R_GY2, R_C1,  1'b0);
      // c0 = -2*f1 + gx0 + 2*f0 + gx1
      7'd62: i = mk(OP_ADD, R_VL1, R_VL1, R_T0,  1'b0);
      7'd63: i = mk(OP_SUB, R_T0,  R_T0,  R_T0,  1'b1);
      7'd64: i = mk(OP_ADD, R_T0,  R_GX0, R_T0,  1'b0);
      7'd65: i = mk(OP_ADD, R_VL0, R_VL0, R_T1,  1'b0);
      7'd66: i = mk(OP_ADD, R_T0,  R_T1,  R_T0,  1'b0);
      7'd67: i = mk(OP_ADD, R_T0,  R_GX1, R_C0,  1'b0);
      // evaluation; T0 = u^2, T1 = v^2
      7'd68: i = mk(OP_MUL, R_U,   R_U,   R_T0,  1'b0);
      7'd69: i = mk(OP_MUL, R_V,   R_V,   R_T1,  1'b0);
      7'd70: i = mk(OP_MUL, R_T0,  R_U,   R_T2,  1'b0);
      7'd71: i = mk(OP_MUL, R_C0,  R_T2,  R_ACC, 1'b0);
      7'd72: i = mk(OP_MUL, R_T1,  R_V,   R_T2,  1'b0);
      7'd73: i = mk(OP_MUL, R_C1,  R_T2,  R_T2,  1'b0);
      7'd74: i = mk(OP_ADD, R_ACC, R_T2,  R_ACC, 1'b0);
      7'd75: i = mk(OP_MUL, R_T0,  R_V,   R_T2,  1'b0);
      7'd76: i = mk(OP_MUL, R_C2,  R_T2,  R_T2,  1'b0);
      7'd77: i = mk(OP_ADD, R_ACC, R_T2,  R_ACC, 1'b0);
      7'd78: i = mk(OP_MUL, R_U,   R_T1,  R_T2,  1'b0);
      7'd79: i = mk(OP_MUL, R_C3,  R_T2,  R_T2,  1'b0);
      7'd80: i = mk(OP_ADD, R_ACC, R_T2,  R_ACC, 1'b0);
      7'd81: i = mk(OP_MUL, R_C4,  R_T0,  R_T2,  1'b0);
      7'd82: i = mk(OP_ADD, R_ACC, R_T2,  R_ACC, 1'b0);
      7'd83: i = mk(OP_MUL, R_C5,  R_T1,  R_T2,  1'b0);
      7'd84: i = mk(OP_ADD, R_ACC, R_T2,  R_ACC, 1'b0);
      7'd85: i = mk(OP_MUL, R_GX0, R_U,   R_T2,  1'b0);
      7'd86: i = mk(OP_ADD, R_ACC, R_T2,  R_ACC, 1'b0);
      7'd87: i = mk(OP_MUL, R_GY0, R_V,   R_T2,  1'b0);
      7'd88: i = mk(OP_ADD, R_ACC, R_T2,  R_ACC, 1'b0);
      7'd89: i = mk(OP_ADD, R_ACC, R_VL0, R_ACC, 1'b0);
      default: i = mk(OP_FIN, R_ACC, R_ACC, R_ACC, 1'b0);
    endcase
    return i;
  endfunction

endpackage

@@ hw/rtl/tchi_req_if.sv @@
interface tchi_req_if import tchi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [1:0]             vertex_index;
  logic signed [IO_W-1:0] pos_x;
  logic signed [IO_W-1:0] pos_y;
  logic signed [IO_W-1:0] sample_value;
  logic signed [IO_W-1:0] slope_x;
  logic signed [IO_W-1:0] slope_y;

  modport source(output valid, kind, vertex_index, pos_x, pos_y, sample_value, slope_x,
                 slope_y, input ready);
  modport sink(input valid, kind, vertex_index, pos_x, pos_y, sample_value, slope_x,
               slope_y, output ready);
endinterface

@@ hw/rtl/tchi_rsp_if.sv @@
interface tchi_rsp_if import tchi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] interp_value;
  logic                   degenerate;
  logic                   saturated;

  modport source(output valid, interp_value, degenerate, saturated, input ready);
  modport sink(input valid, interp_value, degenerate, saturated, output ready);
endinterface

@@ hw/rtl/tchi_ram.sv @@
module tchi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

@@ hw/rtl/tchi_dp.sv @@
module tchi_dp import tchi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [1:0]             vertex_index,
  input  logic signed [IO_W-1:0] pos_x,
  input  logic signed [IO_W-1:0] pos_y,
  input  logic signed [IO_W-1:0] sample_value,
  input  logic signed [IO_W-1:0] slope_x,
  input  logic signed [IO_W-1:0] slope_y,
  output logic signed [IO_W-1:0] interp_value,
  output logic                   degenerate,
  output logic                   saturated
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 1;
  localparam int QW = W + F;
  localparam int CW = $clog2(QW);

  localparam logic signed [64:0] WMAXS = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0] WMINS = -WMAXS - 65'sd1;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] RND = PW'(1) << (F - 1);

  // {clipped, value}
  function automatic logic [W:0] clamp_in(logic signed [IO_W-1:0] x);
    logic signed [64:0] e;
    e = 65'(x);
    if (e > WMAXS) return {1'b1, WMAX};
    if (e < WMINS) return {1'b1, WMIN};
    return {1'b0, W'(e)};
  endfunction

  function automatic logic [W-1:0] mag(logic [W-1:0] a);
    return a[W-1] ? W'(-a) : a;
  endfunction

  logic [1:0]             lat_idx;
  logic signed [IO_W-1:0] lat_x, lat_y, lat_val, lat_sx, lat_sy;

  logic [W-1:0]  rdata_a, rdata_b;
  logic          we;
  logic [ADDR_W-1:0] waddr;
  logic [W-1:0]  wdata;

  logic [2*W-1:0] prod;
  logic           neg;
  logic [QW-1:0]  nsh;
  logic [QW-1:0]  quo;
  logic [W:0]     rem;
  logic [W-1:0]   dden;
  logic [CW-1:0]  cnt;
  logic           clip;

  logic [W-1:0]  av;
  logic [W:0]    sum_as;
  logic [PW-1:0] msum, mq, mlim;
  logic [W-1:0]  mmag;
  logic [QW-1:0] qlim;
  logic [W-1:0]  qmag;
  logic [W:0]    rem_sh;
  logic          rem_ge;
  logic [W-1:0]  res;
  logic          res_sat;
  logic          res_we;
  logic [W:0]    ld_in;
  logic [W:0]    q_in;
  logic signed [63:0] out_ext;

  tchi_ram #(.WIDTH(W), .DEPTH(RF_DEPTH)) u_rf (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(cmd.ra),
    .raddr_b(cmd.rb),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_idx <= vertex_index;
      lat_x   <= pos_x;
      lat_y   <= pos_y;
      lat_val <= sample_value;
      lat_sx  <= slope_x;
      lat_sy  <= slope_y;
    end
  end

  always_comb begin
    case (cmd.ld_sel)
      3'd0:    ld_in = clamp_in(lat_x);
      3'd1:    ld_in = clamp_in(lat_y);
      3'd2:    ld_in = clamp_in(lat_val);
      3'd3:    ld_in = clamp_in(lat_sx);
      default: ld_in = clamp_in(lat_sy);
    endcase
  end

  // add / subtract with saturation
  always_comb begin
    av = cmd.zero_a ? '0 : rdata_a;
    if (cmd.op == OP_SUB) begin
      sum_as = {av[W-1], av} - {rdata_b[W-1], rdata_b};
    end else begin
      sum_as = {av[W-1], av} + {rdata_b[W-1], rdata_b};
    end
  end

  // product: round magnitude half up, then saturate; the quotient magnitude is saturated too
  always_comb begin
    msum = {1'b0, prod} + RND;
    mq   = msum >> F;
    mlim = (PW'(1) << (W - 1)) - PW'(!neg);
    mmag = (mq > mlim) ? mlim[W-1:0] : mq[W-1:0];
    qlim = (QW'(1) << (W - 1)) - QW'(!neg);
    qmag = (quo > qlim) ? qlim[W-1:0] : quo[W-1:0];
  end

  assign rem_sh = {rem[W-1:0], nsh[QW-1]};
  assign rem_ge = rem_sh >= {1'b0, dden};
  assign q_in   = (cmd.op == OP_LDX) ? clamp_in(lat_x) : clamp_in(lat_y);

  always_comb begin
    res     = '0;
    res_sat = 1'b0;
    res_we  = 1'b0;
    case (cmd.op)
      OP_ADD, OP_SUB: begin
        res_we  = 1'b1;
        res_sat = sum_as[W] ^ sum_as[W-1];
        res     = res_sat ? (sum_as[W] ? WMIN : WMAX) : sum_as[W-1:0];
      end
      OP_MUL: begin
        res_we  = 1'b1;
        res_sat = mq > mlim;
        res     = neg ? W'(-mmag) : mmag;
      end
      OP_DIV: begin
        res_we  = 1'b1;
        res_sat = quo > qlim;
        res     = neg ? W'(-qmag) : qmag;
      end
      OP_LDX, OP_LDY: begin
        res_we  = 1'b1;
        res_sat = q_in[W];
        res     = q_in[W-1:0];
      end
      default: begin
        res_we = 1'b0;
      end
    endcase
  end

  assign we    = cmd.ld_we | (cmd.wr & res_we);
  assign waddr = cmd.ld_we ? ADDR_W'(cmd.ld_sel) * ADDR_W'(VERT_N) + ADDR_W'(lat_idx)
                           : cmd.rd;
  assign wdata = cmd.ld_we ? ld_in[W-1:0] : res;

  assign sts.det_zero = (rdata_a == '0);
  assign sts.div_done = (cnt == CW'(QW - 1));

  // multiplier and divider
  always_ff @(posedge clk) begin
    if (cmd.ex) begin
      neg <= rdata_a[W-1] ^ rdata_b[W-1];
      if (cmd.op == OP_MUL) begin
        prod <= (2*W)'(mag(rdata_a)) * (2*W)'(mag(rdata_b));
      end
      nsh  <= QW'(mag(rdata_a)) << F;
      dden <= mag(rdata_b);
      rem  <= '0;
      quo  <= '0;
      cnt  <= '0;
    end else if (cmd.dv) begin
      rem <= rem_ge ? rem_sh - {1'b0, dden} : rem_sh;
      quo <= {quo[QW-2:0], rem_ge};
      nsh <= nsh << 1;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip <= 1'b0;
    end else if (cmd.clr) begin
      clip <= 1'b0;
    end else if (cmd.wr && res_we && res_sat) begin
      clip <= 1'b1;
    end
  end

  assign out_ext = 64'(signed'(rdata_a));

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      if (cmd.op == OP_CHK && sts.det_zero) begin
        interp_value <= '0;
        degenerate   <= 1'b1;
        saturated    <= 1'b0;
      end else if (cmd.op == OP_FIN) begin
        interp_value <= out_ext[IO_W-1:0];
        degenerate   <= 1'b0;
        saturated    <= clip;
      end
    end
  end
endmodule

@@ hw/rtl/tchi_ctrl.sv @@
module tchi_ctrl import tchi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       req_kind,
  input  logic [1:0] req_idx,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_RD   = 7'b0000100,
    S_EX   = 7'b0001000,
    S_DV   = 7'b0010000,
    S_WR   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t          state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic [2:0]      ld_cnt, ld_cnt_next;
  instr_t          instr;
  logic            accept;

  assign instr     = prog(pc);
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign accept    = req_valid & req_ready;

  always_comb begin
    cmd.latch  = accept;
    cmd.clr    = accept && (req_kind == KIND_QUERY);
    cmd.ld_we  = (state == S_LOAD);
    cmd.ld_sel = ld_cnt;
    cmd.op     = instr.op;
    cmd.ra     = instr.ra;
    cmd.rb     = instr.rb;
    cmd.rd     = instr.rd;
    cmd.zero_a = instr.zero_a;
    cmd.ex     = (state == S_EX);
    cmd.dv     = (state == S_DV);
    cmd.wr     = (state == S_WR);
  end

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    ld_cnt_next = ld_cnt;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_kind == KIND_QUERY) begin
            pc_next    = '0;
            state_next = S_RD;
          end else if (req_idx != BAD_IDX) begin
            ld_cnt_next = '0;
            state_next  = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (ld_cnt == 3'(LD_FIELDS - 1)) begin
          ld_cnt_next = '0;
          state_next  = S_IDLE;
        end else begin
          ld_cnt_next = ld_cnt + 3'd1;
        end
      end
      S_RD: state_next = S_EX;
      S_EX: state_next = (instr.op == OP_DIV) ? S_DV : S_WR;
      S_DV: begin
        if (sts.div_done) begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        if (instr.op == OP_FIN || (instr.op == OP_CHK && sts.det_zero)) begin
          state_next = S_OUT;
        end else begin
          pc_next    = pc + 1'b1;
          state_next = S_RD;
        end
      end
      S_OUT: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      ld_cnt <= '0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      ld_cnt <= ld_cnt_next;
    end
  end

  // a load with a bad vertex index is dropped and leaves ready high
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !(req_kind == KIND_LOAD && req_idx == BAD_IDX))
      |=> !req_ready)
    else $error("ready stayed high after an accepted item");

  a_pc_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (pc <= PC_LAST))
    else $error("program counter ran past the end of the program");

  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && instr.op == OP_FIN) |=> rsp_valid)
    else $error("finished query did not present a result");

  a_ld_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (ld_cnt == '0))
    else $error("load counter left nonzero outside a load");
endmodule

@@ hw/rtl/triangle_cubic_hermite_interp.sv @@
// Load item: accepted, then five register-file writes; ready again once the last write is done.
// Query item: a 91-step program; each step is read, execute, write, and the
// two divides add DATA_WIDTH+FRAC_BITS radix-2 steps each; the default format is Q8.24.
// A degenerate triangle stops after the determinant check.
// One item at a time; the result holds until taken, then the next item is accepted.
// Synchronous reset returns the controller to idle; stored vertices are not cleared.
module triangle_cubic_hermite_interp import tchi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tchi_req_if.sink   req,
  tchi_rsp_if.source rsp
);
  cmd_t cmd;
  sts_t sts;

  tchi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .req_kind (req.kind),
    .req_idx  (req.vertex_index),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tchi_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .vertex_index(req.vertex_index),
    .pos_x       (req.pos_x),
    .pos_y       (req.pos_y),
    .sample_value(req.sample_value),
    .slope_x     (req.slope_x),
    .slope_y     (req.slope_y),
    .interp_value(rsp.interp_value),
    .degenerate  (rsp.degenerate),
    .saturated   (rsp.saturated)
  );
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import tchi_pkg::*;

  localparam int W = 32;
  localparam int F = 24;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  typedef struct {
    logic                kind;
    logic [1:0]          vidx;
    logic signed [W-1:0] px, py, val, sx, sy;
  } item_t;

  typedef struct {
    logic signed [W-1:0] value;
    logic                degen;
    logic                sat;
  } answer_t;

  logic clk;
  logic rst;
  tchi_req_if req();
  tchi_rsp_if rsp();

  triangle_cubic_hermite_interp DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  item_t   pending[$];
  answer_t answers[$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_stall = 0;
  int      hold_off = 0;

  // vertex store of the predictor
  longint tri_x[3], tri_y[3], tri_v[3], tri_sx[3], tri_sy[3];
  bit     clipped;

  function automatic longint clamp32(longint a);
    if (a > S_MAX) begin
      clipped = 1;
      return S_MAX;
    end
    if (a < S_MIN) begin
      clipped = 1;
      return S_MIN;
    end
    return a;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clamp32(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clamp32(a - b);
  endfunction

  // exact product, magnitude rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    logic [127:0] m;
    logic [63:0]  ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m = ma * mb;
    m = (m + (128'd1 << (F - 1))) >> F;
    if ((a < 0) != (b < 0)) return clamp32(-$signed({1'b0, m}));
    return clamp32($signed({1'b0, m}));
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic [127:0] mn, q;
    logic [63:0]  mn0, md;
    mn0 = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    mn = {64'd0, mn0} << F;
    q = mn / md;
    if ((n < 0) != (d < 0)) return clamp32(-$signed({1'b0, q}));
    return clamp32($signed({1'b0, q}));
  endfunction

  function automatic void predict_hermite(item_t it);
    longint dx1, dy1, dx2, dy2, det, px, py, u, v, u2, v2, acc;
    longint gx[3], gy[3], c[10];
    answer_t r;
    if (it.kind == KIND_LOAD) begin
      if (it.vidx != BAD_IDX) begin
        tri_x[it.vidx] = it.px;
        tri_y[it.vidx] = it.py;
        tri_v[it.vidx] = it.val;
        tri_sx[it.vidx] = it.sx;
        tri_sy[it.vidx] = it.sy;
      end
      return;
    end
    clipped = 0;
    dx1 = qsub(tri_x[1], tri_x[0]);
    dy1 = qsub(tri_y[1], tri_y[0]);
    dx2 = qsub(tri_x[2], tri_x[0]);
    dy2 = qsub(tri_y[2], tri_y[0]);
    px = qsub(longint'(it.px), tri_x[0]);
    py = qsub(longint'(it.py), tri_y[0]);
    det = qsub(qmul(dx1, dy2), qmul(dx2, dy1));
    if (det == 0) begin
      r.value = 0;
      r.degen = 1;
      r.sat = 0;
      answers.push_back(r);
      return;
    end
    u = qdiv(qsub(qmul(px, dy2), qmul(py, dx2)), det);
    v = qdiv(qsub(qmul(py, dx1), qmul(px, dy1)), det);
    for (int i = 0; i < 3; i++) begin
      gx[i] = qadd(qmul(tri_sx[i], dx1), qmul(tri_sy[i], dy1));
      gy[i] = qadd(qmul(tri_sx[i], dx2), qmul(tri_sy[i], dy2));
    end
    c[9] = tri_v[0];
    c[8] = gy[0];
    c[7] = gx[0];
    c[5] = qsub(qsub(qsub(qadd(qadd(tri_v[2], tri_v[2]), tri_v[2]), qadd(c[8], c[8])),
                     qadd(qadd(c[9], c[9]), c[9])), gy[2]);
    c[4] = qsub(qsub(qsub(qadd(qadd(tri_v[1], tri_v[1]), tri_v[1]), qadd(c[7], c[7])),
                     qadd(qadd(c[9], c[9]), c[9])), gx[1]);
    c[3] = qsub(gx[2], c[7]);
    c[2] = qsub(gy[1], c[8]);
    c[1] = qadd(qadd(qadd(qsub(0, qadd(tri_v[2], tri_v[2])), c[8]), qadd(c[9], c[9])),
                gy[2]);
    c[0] = qadd(qadd(qadd(qsub(0, qadd(tri_v[1], tri_v[1])), c[7]), qadd(c[9], c[9])),
                gx[1]);
    u2 = qmul(u, u);
    v2 = qmul(v, v);
    acc = qmul(c[0], qmul(u2, u));
    acc = qadd(acc, qmul(c[1], qmul(v2, v)));
    acc = qadd(acc, qmul(c[2], qmul(u2, v)));
    acc = qadd(acc, qmul(c[3], qmul(u, v2)));
    acc = qadd(acc, qmul(c[4], u2));
    acc = qadd(acc, qmul(c[5], v2));
    acc = qadd(acc, qmul(c[7], u));
    acc = qadd(acc, qmul(c[8], v));
    acc = qadd(acc, c[9]);
    r.value = acc[W-1:0];
    r.degen = 0;
    r.sat = clipped;
    answers.push_back(r);
  endfunction

  function automatic logic signed [W-1:0] rnd_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $urandom();
      default: return $signed($urandom_range(0, 32'h0600_0000)) - 32'sh0300_0000;
    endcase
  endfunction

  function automatic item_t mk_item(logic kind, logic [1:0] vi, logic signed [W-1:0] x,
                                    logic signed [W-1:0] y, logic signed [W-1:0] f,
                                    logic signed [W-1:0] gx, logic signed [W-1:0] gy);
    item_t it;
    it.kind = kind;
    it.vidx = vi;
    it.px = x;
    it.py = y;
    it.val = f;
    it.sx = gx;
    it.sy = gy;
    return it;
  endfunction

  function automatic void add_random_item(bit load_only);
    if (load_only || $urandom_range(0, 3) == 0)
      pending.push_back(mk_item(KIND_LOAD, 2'($urandom_range(0, 3)), rnd_word(), rnd_word(),
                                rnd_word(), rnd_word(), rnd_word()));
    else
      pending.push_back(mk_item(KIND_QUERY, 2'($urandom()), rnd_word(), rnd_word(),
                                $urandom(), $urandom(), $urandom()));
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL triangle_cubic_hermite_interp");
    $finish;
  end

  // driver; the item on the bus is always pending[0]
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 0;
    end else begin
      if (req.valid && req.ready) begin
        predict_hermite(pending.pop_front());
      end
      if ((req.valid && !req.ready) ||
          (pending.size() > 0 && $urandom_range(0, 99) >= send_idle)) begin
        req.valid <= 1;
        req.kind <= pending[0].kind;
        req.vertex_index <= pending[0].vidx;
        req.pos_x <= pending[0].px;
        req.pos_y <= pending[0].py;
        req.sample_value <= pending[0].val;
        req.slope_x <= pending[0].sx;
        req.slope_y <= pending[0].sy;
      end else begin
        req.valid <= 0;
      end
    end
  end

  // receiver stall and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 0;
    end else begin
      rsp.ready <= $urandom_range(0, 99) >= recv_stall;
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (answers.size() == 0) begin
        $display("%0t: unexpected result value=%h degenerate=%b saturated=%b", $time,
                 rsp.interp_value, rsp.degenerate, rsp.saturated);
        errors++;
      end else begin
        e = answers.pop_front();
        if (rsp.interp_value !== e.value || rsp.degenerate !== e.degen ||
            rsp.saturated !== e.sat) begin
          $display("%0t: expected value=%h degenerate=%b saturated=%b, got %h %b %b", $time,
                   e.value, e.degen, e.sat, rsp.interp_value, rsp.degenerate,
                   rsp.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    req.valid = 0;
    req.kind = 0;
    req.vertex_index = 0;
    req.pos_x = 0;
    req.pos_y = 0;
    req.sample_value = 0;
    req.slope_x = 0;
    req.slope_y = 0;
    rsp.ready = 0;
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: unit triangle, corner and interior queries, degenerate, tiny determinant, extremes
    pending.push_back(mk_item(KIND_LOAD, 2'd0, 0, 0, 32'sh0100_0000, 32'sh0080_0000, 0));
    pending.push_back(mk_item(KIND_LOAD, 2'd1, 32'sh0100_0000, 0, 32'sh0200_0000, 0,
                              32'sh0100_0000));
    pending.push_back(mk_item(KIND_LOAD, 2'd2, 0, 32'sh0100_0000, -32'sh0100_0000,
                              32'sh0040_0000, -32'sh0040_0000));
    pending.push_back(mk_item(KIND_LOAD, 2'd3, 1, 2, 3, 4, 5));
    pending.push_back(mk_item(KIND_QUERY, 2'd3, 0, 0, 0, 0, 0));
    pending.push_back(mk_item(KIND_QUERY, 2'd0, 32'sh0040_0000, 32'sh0040_0000, -1, -1, -1));
    pending.push_back(mk_item(KIND_QUERY, 2'd1, 32'sh7fffffff, 32'sh80000000, 0, 0, 0));
    pending.push_back(mk_item(KIND_QUERY, 2'd2, 32'sh80000000, 32'sh7fffffff, 0, 0, 0));
    pending.push_back(mk_item(KIND_LOAD, 2'd2, 32'sh0200_0000, 0, 0, 0, 0));
    pending.push_back(mk_item(KIND_QUERY, 2'd0, 32'sh0010_0000, 0, 0, 0, 0));
    pending.push_back(mk_item(KIND_LOAD, 2'd2, 1, 1, 32'sh7fffffff, 32'sh7fffffff,
                              32'sh80000000));
    pending.push_back(mk_item(KIND_QUERY, 2'd0, 32'sh0100_0000, 32'sh0100_0000, 0, 0, 0));
    pending.push_back(mk_item(KIND_LOAD, 2'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                              32'sh80000000, 32'sh7fffffff));
    pending.push_back(mk_item(KIND_LOAD, 2'd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                              -1, -1));
    pending.push_back(mk_item(KIND_LOAD, 2'd2, 32'sh80000000, 32'sh7fffffff, -1, 0, 0));
    pending.push_back(mk_item(KIND_QUERY, 2'd0, 0, 0, 0, 0, 0));
    pending.push_back(mk_item(KIND_QUERY, 2'd0, -1, -1, 0, 0, 0));

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      wait (pending.size() == 0);
      send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 36 : 52) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 36 : 52) : 0;
      for (int k = 0; k < 475; k++) begin
        add_random_item(0);
      end
      if (ph == 2) begin
        wait (pending.size() < 470);
        hold_off = 2000;
      end
    end
    // stretch with no idling at the tail
    wait (pending.size() == 0);
    send_idle = 0;
    recv_stall = 0;
    wait (answers.size() == 0 && !req.valid);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("PASS triangle_cubic_hermite_interp");
    end else begin
      $display("FAIL triangle_cubic_hermite_interp");
    end
    $finish;
  end

endmodule
